[rtl/jdp_pkg.sv]
// Shared types, constants and helper functions for the jittered deadline pacer.
// No dependencies; every other file in rtl/ except jdp_div.sv refers to this package by scoped names.
package jdp_pkg;

  // Input beat: item kind and current monotonic time
  typedef struct packed {
    logic        kind;
    logic [63:0] now_ns;
  } jdp_in_t;

  // Result beat: new deadline, drawn period and miss flag
  typedef struct packed {
    logic [63:0] due_ns;
    logic [30:0] period_ns;
    logic        missed;
  } jdp_out_t;

  // Item kinds
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // Register map (word index)
  localparam logic REG_RATE_HZ = 1'b0;

  // Constants
  localparam logic [63:0] RNG_RESET    = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [19:0] RATE_RESET   = 20'd1000;
  localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
  localparam logic [31:0] DIV5_RECIP   = 32'hCCCC_CCCD;
  localparam logic [6:0]  PERIOD_STEPS = 7'd30;
  localparam logic [6:0]  MOD_STEPS    = 7'd64;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PDIV,
    ST_PWAIT,
    ST_SPAN,
    ST_STEP,
    ST_MWAIT,
    ST_DRAW,
    ST_FIN,
    ST_OUT
  } jdp_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic in_load;
    logic div_start;
    logic div_mod;
    logic span_load;
    logic rng_step;
    logic draw_load;
    logic finish;
    logic out_load;
  } jdp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic span_zero;
    logic out_free;
  } jdp_sts_t;

  // One xorshift64 step: left 13, right 7, left 17
  function automatic logic [63:0] xs_next(input logic [63:0] s);
    logic [63:0] a;
    logic [63:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 7);
    return b ^ (b << 17);
  endfunction

endpackage

[rtl/jdp_div.sv]
// Restoring divider, one quotient bit per cycle, variable step count.
// Self-contained; uses nothing from jdp_pkg.
module jdp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  input  logic [6:0]  steps,
  output logic        done,
  output logic [63:0] quot,
  output logic [31:0] rem
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] trial;
  logic [33:0] diff;
  logic        ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, dvd_r[63]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_r};
  assign ge    = ~diff[33];

  // Load on start, then shift one bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      dvd_nxt = {dvd_r[62:0], ge};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

[rtl/jdp_dp.sv]
// Datapath: generator and deadline state, period and span arithmetic, result register.
// Depends on jdp_pkg (types, constants, xs_next) and instantiates jdp_div.
module jdp_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  jdp_pkg::jdp_cmd_t cmd,
  output jdp_pkg::jdp_sts_t sts,
  input  jdp_pkg::jdp_in_t  in_data,
  input  logic [19:0]       rate_hz,
  input  logic              out_stall,
  output logic              out_valid,
  output jdp_pkg::jdp_out_t out_data
);

  logic              kind_r, kind_nxt;
  logic [63:0]       now_r, now_nxt;
  logic [63:0]       rng_r, rng_nxt;
  logic [63:0]       deadline_r, deadline_nxt;
  logic [29:0]       period_r, period_nxt;
  logic [29:0]       span_r, span_nxt;
  logic [30:0]       drawn_r, drawn_nxt;
  logic [30:0]       res_period_r, res_period_nxt;
  logic              res_miss_r, res_miss_nxt;
  logic              out_valid_r, out_valid_nxt;
  jdp_pkg::jdp_out_t out_data_r, out_data_nxt;

  logic [19:0] rate_eff;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  logic [6:0]  div_steps;
  logic        div_done;
  logic [63:0] div_quot;
  logic [31:0] div_rem;
  logic [63:0] rng_stepped;
  logic [31:0] x3;
  logic [63:0] prod;
  logic [29:0] extra;
  logic [63:0] sum;

  // Treat a zero rate as the lowest rate
  assign rate_eff    = (rate_hz == '0) ? 20'd1 : rate_hz;
  assign rng_stepped = jdp_pkg::xs_next(rng_r);

  // Divider operand select: nominal period or remainder of the draw
  always_comb begin
    if (cmd.div_mod) begin
      div_dividend = rng_stepped;
      div_divisor  = {2'b00, span_r};
      div_steps    = jdp_pkg::MOD_STEPS;
    end else begin
      div_dividend = {jdp_pkg::NS_PER_SEC, 34'd0};
      div_divisor  = {12'd0, rate_eff};
      div_steps    = jdp_pkg::PERIOD_STEPS;
    end
  end

  jdp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // span = period*3/5 through the reciprocal of five
  assign x3   = {2'b00, div_quot[29:0]} + {1'b0, div_quot[29:0], 1'b0};
  assign prod = x3 * jdp_pkg::DIV5_RECIP;

  assign extra = (span_r == '0) ? 30'd0 : div_rem[29:0];
  assign sum   = deadline_r + {33'd0, drawn_r};

  always_comb begin
    kind_nxt       = kind_r;
    now_nxt        = now_r;
    rng_nxt        = rng_r;
    deadline_nxt   = deadline_r;
    period_nxt     = period_r;
    span_nxt       = span_r;
    drawn_nxt      = drawn_r;
    res_period_nxt = res_period_r;
    res_miss_nxt   = res_miss_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    // Capture the accepted beat
    if (cmd.in_load) begin
      kind_nxt = in_data.kind;
      now_nxt  = in_data.now_ns;
    end

    // Latch nominal period and span
    if (cmd.span_load) begin
      period_nxt = div_quot[29:0];
      span_nxt   = prod[63:34];
    end

    // Advance the generator
    if (cmd.rng_step) begin
      rng_nxt = rng_stepped;
    end

    // Jittered period: period - span/2 + remainder
    if (cmd.draw_load) begin
      drawn_nxt = {1'b0, period_r} - {2'b00, span_r[29:1]} + {1'b0, extra};
    end

    // Update deadline and result fields
    if (cmd.finish) begin
      if (kind_r == jdp_pkg::KIND_START) begin
        rng_nxt        = rng_r ^ (now_r | 64'd1);
        deadline_nxt   = now_r;
        res_period_nxt = '0;
        res_miss_nxt   = 1'b0;
      end else begin
        res_period_nxt = drawn_r;
        if (sum <= now_r) begin
          deadline_nxt = now_r;
          res_miss_nxt = 1'b1;
        end else begin
          deadline_nxt = sum;
          res_miss_nxt = 1'b0;
        end
      end
    end

    // Output register: drop on take, load on command
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.due_ns    = deadline_r;
      out_data_nxt.period_ns = res_period_r;
      out_data_nxt.missed    = res_miss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r       <= jdp_pkg::RNG_RESET;
      deadline_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rng_r       <= rng_nxt;
      deadline_r  <= deadline_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    now_r        <= now_nxt;
    period_r     <= period_nxt;
    span_r       <= span_nxt;
    drawn_r      <= drawn_nxt;
    res_period_r <= res_period_nxt;
    res_miss_r   <= res_miss_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign sts.div_done  = div_done;
  assign sts.span_zero = (span_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

[rtl/jdp_ctrl.sv]
// Controller state machine: sequences accept, divides, draw, update and result load.
// Depends on jdp_pkg (state enum, command and status structs).
module jdp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  input  jdp_pkg::jdp_sts_t sts,
  output jdp_pkg::jdp_cmd_t cmd
);

  jdp_pkg::jdp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jdp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      jdp_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = (in_kind == jdp_pkg::KIND_ADVANCE) ? jdp_pkg::ST_PDIV
                                                           : jdp_pkg::ST_FIN;
        end
      end
      jdp_pkg::ST_PDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = jdp_pkg::ST_PWAIT;
      end
      jdp_pkg::ST_PWAIT: begin
        if (sts.div_done) begin
          state_nxt = jdp_pkg::ST_SPAN;
        end
      end
      jdp_pkg::ST_SPAN: begin
        cmd.span_load = 1'b1;
        state_nxt     = jdp_pkg::ST_STEP;
      end
      jdp_pkg::ST_STEP: begin
        // Skip the generator when the span is empty
        if (sts.span_zero) begin
          state_nxt = jdp_pkg::ST_DRAW;
        end else begin
          cmd.rng_step  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_mod   = 1'b1;
          state_nxt     = jdp_pkg::ST_MWAIT;
        end
      end
      jdp_pkg::ST_MWAIT: begin
        if (sts.div_done) begin
          state_nxt = jdp_pkg::ST_DRAW;
        end
      end
      jdp_pkg::ST_DRAW: begin
        cmd.draw_load = 1'b1;
        state_nxt     = jdp_pkg::ST_FIN;
      end
      jdp_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = jdp_pkg::ST_OUT;
      end
      jdp_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = jdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jdp_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != jdp_pkg::ST_IDLE);

endmodule

[rtl/jittered_deadline_pacer_unit.sv]
// Jittered deadline pacer top level: rate register, controller and datapath.
// Depends on jdp_pkg and instantiates jdp_ctrl and jdp_dp.
//
// Usage: each input beat carries kind and now_ns. A start beat seeds the
// xorshift generator with the time and sets the deadline to it; an advance
// beat draws a period of 1e9/rate_hz ns with +-30% jitter, adds it to the
// deadline and flags a miss if the result is not after now. One result beat
// follows each input beat, in order.
// Sequence: a start beat goes from acceptance straight to the deadline
// update and result load. An advance beat first uses the shared bit-serial
// divider twice: 30 steps for the nominal period and 64 steps for the
// remainder of the draw, the second skipped when the span is zero.
// Flow control: one item at a time; in_stall is low only while idle. A
// finished result sits in the output register, so the next beat is accepted
// while it waits; a stalled receiver holds the controller only when a second
// result is ready. The user must write rate_hz through the cfg_ APB port at
// word 0 while idle; the block itself does not enforce this.
// Reset (rst_n low, synchronous) restores rate 1000, the generator seed and a
// zero deadline, and empties the output register.
module jittered_deadline_pacer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  jdp_pkg::jdp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output jdp_pkg::jdp_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [19:0]       rate_r, rate_nxt;
  logic              cfg_wr;
  jdp_pkg::jdp_cmd_t cmd;
  jdp_pkg::jdp_sts_t sts;

  // Configuration register write and readback
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    rate_nxt = rate_r;
    if (cfg_wr && (cfg_paddr[2] == jdp_pkg::REG_RATE_HZ)) begin
      rate_nxt = cfg_pwdata[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= jdp_pkg::RATE_RESET;
    end else begin
      rate_r <= rate_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == jdp_pkg::REG_RATE_HZ) ? {12'd0, rate_r} : 32'd0;

  jdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  jdp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .rate_hz   (rate_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // One item at a time: the beat after an accept is always stalled
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item was in flight");

  // A miss only comes from an advance, which always draws a nonzero period
  a_miss_has_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.missed) |-> (out_data.period_ns != '0))
    else $error("miss flagged without a drawn period");

  // The drawn period stays within the jitter bound
  a_period_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.period_ns <= 31'd1300000000))
    else $error("drawn period out of range");

  // The result register is loaded only when it is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

endmodule
